### rtl/lpg_pkg.sv
// Shared types and constants for the line point generator.
// No dependencies; imported by the controller, datapath, top level and checker.
package lpg_pkg;

	localparam int LAYER_W = 8;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take a new line command
		logic emit;   // move the current point into the output register and step
	} lpg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_end; // current point equals the end point
	} lpg_status_t;

endpackage

### rtl/lpg_ctrl.sv
// Controller for the line point generator: idle/run sequencing and output beat valid.
// Depends on lpg_pkg.
module lpg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  lpg_pkg::lpg_status_t status,
	output lpg_pkg::lpg_cmd_t    cmd
);
	import lpg_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd.load = s_tvalid && (state_q == ST_IDLE);
		cmd.emit = (state_q == ST_RUN) && out_free;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					// leave once the end point has gone into the output register
					if (cmd.emit && status.at_end)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/lpg_datapath.sv
// Datapath for the line point generator: command registers, error-term step unit
// and the output point register. Depends on lpg_pkg.
module lpg_datapath #(
	parameter int COORD_BITS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpg_pkg::lpg_cmd_t           cmd,
	input  logic [COORD_BITS-1:0]       start_x,
	input  logic [COORD_BITS-1:0]       start_y,
	input  logic [COORD_BITS-1:0]       end_x,
	input  logic [COORD_BITS-1:0]       end_y,
	input  logic [lpg_pkg::LAYER_W-1:0] layer,
	output lpg_pkg::lpg_status_t        status,
	output logic [COORD_BITS-1:0]       point_x,
	output logic [COORD_BITS-1:0]       point_y,
	output logic [lpg_pkg::LAYER_W-1:0] point_layer,
	output logic                        last_point
);
	import lpg_pkg::*;

	localparam int ERR_W = COORD_BITS + 2; // holds -(span_y) .. span_x
	localparam int E2_W  = ERR_W + 1;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [COORD_BITS-1:0] span_x_q, span_y_q;
	logic                  step_x_down_q, step_y_down_q;
	logic signed [ERR_W-1:0] error_q;
	logic [LAYER_W-1:0]    layer_q;

	logic [COORD_BITS-1:0] point_x_q, point_y_q;
	logic [LAYER_W-1:0]    point_layer_q;
	logic                  last_point_q;

	// command setup
	logic                  ld_x_down, ld_y_down;
	logic [COORD_BITS-1:0] ld_span_x, ld_span_y;
	logic signed [ERR_W-1:0] ld_error;

	// step unit
	logic signed [E2_W-1:0] e2, sx_ext, sy_ext, err_sum;
	logic                   x_step, y_step, at_end;

	always_comb begin
		ld_x_down = !(start_x < end_x);
		ld_y_down = !(start_y < end_y);
		ld_span_x = ld_x_down ? start_x - end_x : end_x - start_x;
		ld_span_y = ld_y_down ? start_y - end_y : end_y - start_y;
		ld_error  = $signed({2'b00, ld_span_x}) - $signed({2'b00, ld_span_y});
	end

	always_comb begin
		at_end  = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		e2      = {error_q, 1'b0};
		sx_ext  = $signed({3'b000, span_x_q});
		sy_ext  = $signed({3'b000, span_y_q});
		x_step  = e2 > -sy_ext;
		y_step  = e2 < sx_ext;
		err_sum = {error_q[ERR_W-1], error_q}
			- (x_step ? sy_ext : '0)
			+ (y_step ? sx_ext : '0);
	end

	assign status.at_end = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			span_x_q      <= '0;
			span_y_q      <= '0;
			step_x_down_q <= 1'b0;
			step_y_down_q <= 1'b0;
			error_q       <= '0;
			layer_q       <= '0;
			point_x_q     <= '0;
			point_y_q     <= '0;
			point_layer_q <= '0;
			last_point_q  <= 1'b0;
		end else if (cmd.load) begin
			cur_x_q       <= start_x;
			cur_y_q       <= start_y;
			goal_x_q      <= end_x;
			goal_y_q      <= end_y;
			span_x_q      <= ld_span_x;
			span_y_q      <= ld_span_y;
			step_x_down_q <= ld_x_down;
			step_y_down_q <= ld_y_down;
			error_q       <= ld_error;
			layer_q       <= layer;
		end else if (cmd.emit) begin
			point_x_q     <= cur_x_q;
			point_y_q     <= cur_y_q;
			point_layer_q <= layer_q;
			last_point_q  <= at_end;
			error_q       <= err_sum[ERR_W-1:0];
			if (x_step)
				cur_x_q <= step_x_down_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
			if (y_step)
				cur_y_q <= step_y_down_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
		end
	end

	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign point_layer = point_layer_q;
	assign last_point  = last_point_q;

endmodule

### rtl/line_point_generator_core.sv
// Line point generator top level: stream ports, controller and datapath.
// Depends on lpg_pkg, lpg_ctrl and lpg_datapath.
//
// Takes one line command per slave beat and returns every grid point of the
// line, start to end, one master beat per point, the end point marked by tlast.
// A line of N points (N = max(|dx|,|dy|) + 1, at most 2^COORD_BITS) occupies
// the block while its command is loaded, then while the single error-term step
// unit produces its points in turn. s_tready is low while a line is in progress;
// the next command is taken as soon as the end point is in the output register,
// even if that beat has not yet been taken. Master stalls hold the step unit.
module line_point_generator_core #(
	parameter int COORD_BITS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// start_x, start_y, end_x, end_y, layer (zero padded to bytes)
	input  logic [((4*COORD_BITS+lpg_pkg::LAYER_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// point_x, point_y, point_layer (zero padded to bytes)
	output logic [((2*COORD_BITS+lpg_pkg::LAYER_W+7)/8)*8-1:0] m_tdata,
	output logic m_tlast  // last_point
);
	import lpg_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int OUT_W  = 2*C + LAYER_W;
	localparam int OUT_TW = ((OUT_W+7)/8)*8;

	lpg_cmd_t    cmd;
	lpg_status_t status;

	logic [C-1:0]       point_x, point_y;
	logic [LAYER_W-1:0] point_layer;

	lpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lpg_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.start_x     (s_tdata[C-1:0]),
		.start_y     (s_tdata[2*C-1:C]),
		.end_x       (s_tdata[3*C-1:2*C]),
		.end_y       (s_tdata[4*C-1:3*C]),
		.layer       (s_tdata[4*C+LAYER_W-1:4*C]),
		.status      (status),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_layer (point_layer),
		.last_point  (m_tlast)
	);

	assign m_tdata = OUT_TW'({point_layer, point_y, point_x});

endmodule

### rtl/lpg_checker.sv
// Port-level checks for line_point_generator_core, attached by bind.
// Depends on lpg_pkg for the layer width.
module lpg_checker #(
	parameter int COORD_BITS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((2*COORD_BITS+lpg_pkg::LAYER_W+7)/8)*8-1:0] m_tdata,
	input logic m_tlast
);
	import lpg_pkg::*;

	// a command beat starts a line, so no second command the next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command taken while a line is in progress");

	// the block only frees up when the end point has reached the output
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> (m_tvalid && m_tlast))
		else $error("ready without the end point on the output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("output beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
		else $error("output beat changed under stall");

endmodule

bind line_point_generator_core lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
